FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

// Checked every clock edge, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`else

`define ASSERT_CHK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: sv/wrbd_pkg.sv
package wrbd_pkg;

  localparam int WINDOW_DEF = 15;

  localparam int RATE_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTRABITE_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERBITE_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ENABLE  = 3'd4;

  localparam logic signed [RATE_W-1:0] RISE_THRESHOLD_RST = 16'sd2560;
  localparam logic signed [RATE_W-1:0] FALL_THRESHOLD_RST = -16'sd2560;
  localparam logic [15:0] INTRABITE_MS_RST = 16'd2000;
  localparam logic [15:0] INTERBITE_MS_RST = 16'd8000;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_WAIT  = 2'd2
  } phase_t;

endpackage

FILE: sv/wrist_roll_bite_detector.sv
// Channel   Dir  Handshake            Word
// input     in   in_valid/in_stall    roll_rate, time_ms
// output    out  out_valid/out_stall  smoothed_rate, bite_found, sample_number,
//                                     bites_total, phase
// config    in   cfg_write            cfg_index, cfg_data
//
// One word per cycle unless the output stalls; an accepted word passes the
// window update, reciprocal multiply for the average, detector + output reg.
// The detector phase register closes a loop, as do the window sum and counters.
// rst is synchronous; it clears window fill count, sum, detector and counters.
// A stalled valid output freezes all three stages and raises in_stall.
`include "assert_macros.svh"

module wrist_roll_bite_detector #(
  parameter int WINDOW = wrbd_pkg::WINDOW_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [wrbd_pkg::RATE_W-1:0]     roll_rate,
  input  logic [wrbd_pkg::TIME_W-1:0]            time_ms,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [wrbd_pkg::RATE_W-1:0]     smoothed_rate,
  output logic                                   bite_found,
  output logic [31:0]                            sample_number,
  output logic [15:0]                            bites_total,
  output logic [1:0]                             phase,
  input  logic                                   cfg_write,
  input  logic [wrbd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wrbd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int RATE_W = wrbd_pkg::RATE_W;
  localparam int TIME_W = wrbd_pkg::TIME_W;
  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SUM_W  = RATE_W + LOG_W;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  // floor(s / WINDOW) via biased unsigned n and round-up reciprocal
  localparam int N_W    = SUM_W + 1;
  localparam int M_W    = N_W + 1;
  localparam int P_W    = N_W + M_W;
  localparam int SHIFT  = N_W + LOG_W;
  localparam longint unsigned QOFF  = 64'd1 << (SUM_W - LOG_W);
  localparam longint unsigned BIAS  = WINDOW * QOFF;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;

  // configuration
  logic signed [RATE_W-1:0] rise_threshold;
  logic signed [RATE_W-1:0] fall_threshold;
  logic [15:0]              intrabite_ms;
  logic [15:0]              interbite_ms;
  logic                     smooth_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_threshold <= wrbd_pkg::RISE_THRESHOLD_RST;
      fall_threshold <= wrbd_pkg::FALL_THRESHOLD_RST;
      intrabite_ms   <= wrbd_pkg::INTRABITE_MS_RST;
      interbite_ms   <= wrbd_pkg::INTERBITE_MS_RST;
      smooth_enable  <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wrbd_pkg::REG_RISE_THRESHOLD: rise_threshold <= $signed(cfg_data);
        wrbd_pkg::REG_FALL_THRESHOLD: fall_threshold <= $signed(cfg_data);
        wrbd_pkg::REG_INTRABITE_MS:   intrabite_ms   <= cfg_data;
        wrbd_pkg::REG_INTERBITE_MS:   interbite_ms   <= cfg_data;
        wrbd_pkg::REG_SMOOTH_ENABLE:  smooth_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic advance;
  logic accept;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // stage 1: window ring and running sum
  logic signed [RATE_W-1:0] window_store [WINDOW];
  logic signed [SUM_W-1:0]  window_sum;
  logic signed [SUM_W-1:0]  window_sum_next;
  logic [SLOT_W-1:0]        write_slot;
  logic [CNT_W-1:0]         warmup_count;
  logic                     warm;
  logic signed [RATE_W-1:0] old_rate;

  logic                     s1_valid;
  logic signed [RATE_W-1:0] s1_rate;
  logic [TIME_W-1:0]        s1_time;
  logic                     s1_warm;
  logic signed [SUM_W-1:0]  s1_sum;

  // slots not yet written while warming up read as zero
  assign warm            = warmup_count < CNT_W'(WINDOW);
  assign old_rate        = warm ? '0 : window_store[write_slot];
  assign window_sum_next = window_sum - SUM_W'(old_rate) + SUM_W'(roll_rate);

  always_ff @(posedge clk) begin
    if (accept) begin
      window_store[write_slot] <= roll_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum   <= '0;
      write_slot   <= '0;
      warmup_count <= '0;
    end else if (accept) begin
      window_sum <= window_sum_next;
      if (write_slot == SLOT_W'(WINDOW - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
      if (warm) begin
        warmup_count <= warmup_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rate <= roll_rate;
      s1_time <= time_ms;
      s1_warm <= warm;
      s1_sum  <= window_sum_next;
    end
  end

  // stage 2: floor average
  logic [N_W-1:0]           biased;
  logic [P_W-1:0]           product;
  logic [N_W-1:0]           quot;
  logic signed [RATE_W-1:0] avg;

  assign biased  = N_W'(s1_sum) + N_W'(BIAS);
  assign product = P_W'(biased) * P_W'(M_W'(RECIP));
  assign quot    = N_W'(product >> SHIFT);
  assign avg     = RATE_W'(quot - N_W'(QOFF));

  logic                     s2_valid;
  logic signed [RATE_W-1:0] s2_rate;
  logic [TIME_W-1:0]        s2_time;
  logic                     s2_warm;
  logic signed [RATE_W-1:0] s2_avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_rate <= s1_rate;
      s2_time <= s1_time;
      s2_warm <= s1_warm;
      s2_avg  <= avg;
    end
  end

  // stage 3: detector
  wrbd_pkg::phase_t         detect_phase;
  wrbd_pkg::phase_t         detect_phase_next;
  logic [TIME_W-1:0]        arm_time;
  logic [TIME_W-1:0]        bite_time;
  logic [15:0]              bite_count;
  logic [15:0]              bite_count_next;
  logic [31:0]              sample_counter;
  logic signed [RATE_W-1:0] rate;
  logic                     bite;
  logic                     bite_now;
  logic                     step;

  assign step     = advance && s2_valid;
  assign rate     = (smooth_enable && !s2_warm) ? s2_avg : s2_rate;
  assign bite_now = step && bite;

  always_comb begin
    detect_phase_next = detect_phase;
    bite              = 1'b0;
    unique case (detect_phase)
      wrbd_pkg::PH_IDLE: begin
        if (rate > rise_threshold) begin
          detect_phase_next = wrbd_pkg::PH_ARMED;
        end
      end
      wrbd_pkg::PH_ARMED: begin
        if (rate < fall_threshold && (s2_time - arm_time) >= TIME_W'(intrabite_ms)) begin
          detect_phase_next = wrbd_pkg::PH_WAIT;
          bite              = 1'b1;
        end
      end
      wrbd_pkg::PH_WAIT: begin
        if ((s2_time - bite_time) >= TIME_W'(interbite_ms)) begin
          detect_phase_next = wrbd_pkg::PH_IDLE;
        end
      end
      default: detect_phase_next = wrbd_pkg::PH_IDLE;
    endcase
  end

  assign bite_count_next = (bite && bite_count != 16'hFFFF) ? bite_count + 16'd1 : bite_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_phase   <= wrbd_pkg::PH_IDLE;
      arm_time       <= '0;
      bite_time      <= '0;
      bite_count     <= '0;
      sample_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= s2_valid;
      end
      if (step) begin
        detect_phase   <= detect_phase_next;
        sample_counter <= sample_counter + 32'd1;
        bite_count     <= bite_count_next;
        if (detect_phase == wrbd_pkg::PH_IDLE && detect_phase_next == wrbd_pkg::PH_ARMED) begin
          arm_time <= s2_time;
        end
        if (bite) begin
          bite_time <= s2_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      smoothed_rate <= rate;
      bite_found    <= bite;
      sample_number <= sample_counter;
      bites_total   <= bite_count_next;
      phase         <= detect_phase_next;
    end
  end

  `ASSERT_CHK(a_bite_enters_wait, clk, rst, out_valid && bite_found |-> phase == 2'(wrbd_pkg::PH_WAIT) && bites_total != 16'd0)
  `ASSERT_CHK(a_count_only_on_bite, clk, rst, !$past(rst) && bite_count != $past(bite_count) |-> $past(bite_now))
  `ASSERT_CHK(a_warmup_slot_aligned, clk, rst, warm |-> CNT_W'(write_slot) == warmup_count)
  `ASSERT_CHK(a_warmup_bounded, clk, rst, warmup_count <= CNT_W'(WINDOW))

endmodule
